/* design/sps_pkg.sv */
// Shared types, constants and the ordering function of the sprite sort-and-batch block.
package sps_pkg;

  localparam int unsigned TEX_W      = 32;
  localparam int unsigned DEPTH_W    = 32;
  localparam int unsigned IDX_W      = 6;
  localparam int unsigned VOFF_W     = 9;
  localparam int unsigned VERTS_PER  = 6;

  localparam logic [1:0] MODE_ARRIVAL    = 2'd0;
  localparam logic [1:0] MODE_DEPTH_ASC  = 2'd1;
  localparam logic [1:0] MODE_DEPTH_DESC = 2'd2;
  localparam logic [1:0] MODE_TEXTURE    = 2'd3;

  // Byte address of the sort mode register on the register port.
  localparam logic [1:0] SORT_MODE_ADDR = 2'd0;

  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  typedef struct packed {
    logic [TEX_W-1:0]          texture;
    logic signed [DEPTH_W-1:0] depth;
    logic [IDX_W-1:0]          index;
  } entry_t;

  typedef struct packed {
    logic       load;
    logic       sort;
    logic       odd_phase;
    logic       shift;
    logic [1:0] mode;
  } cell_ctl_t;

  // True when entry a must be placed strictly before entry b.
  function automatic logic goes_before(logic [1:0] mode, entry_t a, entry_t b);
    logic r;
    unique case (mode)
      MODE_DEPTH_ASC:  r = a.depth < b.depth;
      MODE_DEPTH_DESC: r = a.depth > b.depth;
      MODE_TEXTURE:    r = a.texture < b.texture;
      default:         r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

/* design/sps_cell.sv */
// One cell of the sprite chain: holds an entry, loads, shifts and compare-exchanges with neighbours.
module sps_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 7
) (
  input  logic               clk,
  input  sps_pkg::cell_ctl_t ctl,
  input  logic [CNT_W-1:0]   count,
  input  sps_pkg::entry_t    new_entry,
  input  sps_pkg::entry_t    left_entry,
  input  sps_pkg::entry_t    right_entry,
  output sps_pkg::entry_t    entry
);

  localparam logic PAR      = 1'(IDX % 2);
  localparam logic HAS_LEFT = (IDX > 0);

  logic            left_act;
  logic            right_act;
  logic            swap_l;
  logic            swap_r;
  sps_pkg::entry_t entry_next;

  // A pair (i, i+1) is active when i matches the phase parity and both hold sprites.
  assign left_act  = ctl.sort && (PAR == ctl.odd_phase) && (count > CNT_W'(IDX + 1));
  assign right_act = ctl.sort && HAS_LEFT && (PAR != ctl.odd_phase) && (count > CNT_W'(IDX));
  assign swap_l = left_act && sps_pkg::goes_before(ctl.mode, right_entry, entry);
  assign swap_r = right_act && sps_pkg::goes_before(ctl.mode, entry, left_entry);

  always_comb begin
    priority if (ctl.load && count == CNT_W'(IDX)) begin
      entry_next = new_entry;
    end else if (ctl.shift || swap_l) begin
      entry_next = right_entry;
    end else if (swap_r) begin
      entry_next = left_entry;
    end else begin
      entry_next = entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

/* design/sprite_sort_and_batch.sv */
// Top level of the sprite sort-and-batch block: command port, register port, chain and drain.
// An add is taken while the block is idle and leaves it idle and ready for the next command.
// A finish with sprites stored runs MAX_SPRITES odd-even sort phases over the cell chain,
// then drains one result per cycle; busy stays high from the finish beat until the last
// result has been drained.
// Results cannot be stalled. Reset clears the sprite count, overflow flag and state, and
// sets sort_mode to texture ascending; the cell contents are not cleared.
module sprite_sort_and_batch #(
  parameter int MAX_SPRITES = 64
) (
  input  logic        clk,
  input  logic        rst,
  // Command channel.
  input  logic        start,
  output logic        busy,
  input  logic        command,
  input  logic [31:0] texture_id,
  input  logic signed [31:0] depth,
  // Result channel.
  output logic        strobe,
  output logic [5:0]  sprite_index,
  output logic [8:0]  vertex_offset,
  output logic        starts_run,
  output logic        ends_run,
  output logic [31:0] run_texture,
  output logic [8:0]  run_vertex_count,
  output logic        overflow,
  output logic        last,
  // Register port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CNT_W = $clog2(MAX_SPRITES + 1);
  localparam int PH_W  = $clog2(MAX_SPRITES);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SORT  = 3'b010,
    S_DRAIN = 3'b100
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   count;
  logic               dropped;
  logic [1:0]         sort_mode;
  logic [PH_W-1:0]    phase;
  logic               first;
  logic [sps_pkg::TEX_W-1:0]  prev_tex;
  logic [sps_pkg::VOFF_W-1:0] voff;
  logic [sps_pkg::VOFF_W-1:0] runv;

  sps_pkg::cell_ctl_t ctl;
  sps_pkg::entry_t    new_entry;
  sps_pkg::entry_t    chain [MAX_SPRITES];

  logic accept;
  logic cfg_write;
  logic drain_starts;
  logic drain_ends;
  logic [sps_pkg::VOFF_W-1:0] runv_next;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // The register port never waits; the only register is the sort mode at address zero.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr == sps_pkg::SORT_MODE_ADDR);
  assign prdata    = (paddr == sps_pkg::SORT_MODE_ADDR) ? {30'd0, sort_mode} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      sort_mode <= sps_pkg::MODE_TEXTURE;
    end else if (cfg_write) begin
      sort_mode <= pwdata[1:0];
    end
  end

  // Chain control. Adds go into the cell whose position equals the current count;
  // sorting alternates even and odd pairs; draining moves every entry one cell
  // towards the head each cycle.
  always_comb begin
    ctl.load      = accept && (command == sps_pkg::CMD_ADD) &&
                    (count < CNT_W'(MAX_SPRITES));
    ctl.sort      = (state == S_SORT);
    ctl.odd_phase = phase[0];
    ctl.shift     = (state == S_DRAIN);
    ctl.mode      = sort_mode;
  end

  assign new_entry.texture = texture_id;
  assign new_entry.depth   = depth;
  assign new_entry.index   = sps_pkg::IDX_W'(count);

  for (genvar i = 0; i < MAX_SPRITES; i++) begin : g_cell
    sps_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .count       (count),
      .new_entry   (new_entry),
      .left_entry  (chain[(i == 0) ? 0 : i - 1]),
      .right_entry (chain[(i == MAX_SPRITES - 1) ? i : i + 1]),
      .entry       (chain[i])
    );
  end

  // While draining, the head cell holds the sprite being emitted and the next cell
  // its successor in sorted order, which settles whether the texture run closes here.
  // The count doubles as the number of sprites still to emit.
  assign drain_starts = first || (chain[0].texture != prev_tex);
  assign drain_ends   = (count == CNT_W'(1)) || (chain[1].texture != chain[0].texture);
  assign runv_next    = drain_starts ? sps_pkg::VOFF_W'(sps_pkg::VERTS_PER)
                                     : runv + sps_pkg::VOFF_W'(sps_pkg::VERTS_PER);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      dropped <= 1'b0;
      phase   <= '0;
      strobe  <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (command == sps_pkg::CMD_ADD) begin
              if (count < CNT_W'(MAX_SPRITES)) begin
                count <= count + CNT_W'(1);
              end else begin
                dropped <= 1'b1;
              end
            end else if (count == '0) begin
              // An empty finish gives no results but still clears the overflow flag.
              dropped <= 1'b0;
            end else begin
              phase <= '0;
              state <= S_SORT;
            end
          end
        end
        S_SORT: begin
          phase <= phase + PH_W'(1);
          if (phase == PH_W'(MAX_SPRITES - 1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          strobe <= 1'b1;
          count  <= count - CNT_W'(1);
          if (count == CNT_W'(1)) begin
            dropped <= 1'b0;
            state   <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result registers and the running offset and run-length accumulators.
  always_ff @(posedge clk) begin
    if (state == S_SORT) begin
      first <= 1'b1;
      voff  <= '0;
    end else if (state == S_DRAIN) begin
      first    <= 1'b0;
      prev_tex <= chain[0].texture;
      voff     <= voff + sps_pkg::VOFF_W'(sps_pkg::VERTS_PER);
      runv     <= runv_next;

      sprite_index     <= chain[0].index;
      vertex_offset    <= voff;
      starts_run       <= drain_starts;
      ends_run         <= drain_ends;
      run_texture      <= chain[0].texture;
      run_vertex_count <= drain_ends ? runv_next : '0;
      overflow         <= dropped;
      last             <= (count == CNT_W'(1));
    end
  end

endmodule
